@@ rtl/core/p2a_pkg.sv @@
`default_nettype none
package p2a_pkg;

  localparam int unsigned FMT_W = 3;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_DATA_W = 8;

  // source formats
  localparam logic [FMT_W-1:0] FMT_MONO   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_MASK   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGBX   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB    = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA   = 3'd4;
  localparam logic [FMT_W-1:0] FMT_ARGB32 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_RGBM   = 3'd6;
  localparam logic [FMT_W-1:0] FMT_MRGB32 = 3'd7;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_FORMAT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK_RED      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK_GREEN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK_BLUE     = 3'd3;

  localparam logic [FMT_W-1:0] SOURCE_FORMAT_RESET = FMT_ARGB32;
  localparam logic [7:0] OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       end_of_row;
  } pixel_t;

  typedef struct packed {
    logic [31:0] argb_word;
    logic        end_of_row_out;
  } result_t;

  typedef struct packed {
    logic [FMT_W-1:0] source_format;
    logic [7:0]       mask_red;
    logic [7:0]       mask_green;
    logic [7:0]       mask_blue;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/p2a_cfg.sv @@
`default_nettype none
module p2a_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [p2a_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [p2a_pkg::REG_DATA_W-1:0]   cfg_data,
  output p2a_pkg::cfg_t                         cfg
);

  p2a_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.source_format <= p2a_pkg::SOURCE_FORMAT_RESET;
      regs.mask_red      <= 8'd0;
      regs.mask_green    <= 8'd0;
      regs.mask_blue     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        p2a_pkg::REG_SOURCE_FORMAT: regs.source_format <= cfg_data[p2a_pkg::FMT_W-1:0];
        p2a_pkg::REG_MASK_RED:      regs.mask_red      <= cfg_data;
        p2a_pkg::REG_MASK_GREEN:    regs.mask_green    <= cfg_data;
        p2a_pkg::REG_MASK_BLUE:     regs.mask_blue     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/p2a_conv.sv @@
`default_nettype none
module p2a_conv (
  input  wire p2a_pkg::pixel_t pix,
  input  wire p2a_pkg::cfg_t   cfg,
  output p2a_pkg::result_t     res
);

  logic [7:0]  alpha;
  logic [7:0]  c_r;
  logic [7:0]  c_g;
  logic [7:0]  c_b;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [31:0] word;

  // operand select for the three shared premultiply multipliers
  always_comb begin
    alpha = pix.byte3;
    c_r   = pix.byte0;
    c_g   = pix.byte1;
    c_b   = pix.byte2;
    case (cfg.source_format)
      p2a_pkg::FMT_MASK: begin
        alpha = p2a_pkg::OPAQUE - pix.byte0;
        c_r   = cfg.mask_red;
        c_g   = cfg.mask_green;
        c_b   = cfg.mask_blue;
      end
      p2a_pkg::FMT_MRGB32: begin
        c_r = pix.byte2;
        c_b = pix.byte0;
      end
      default: ;
    endcase
  end

  assign prod_r = {8'd0, c_r} * {8'd0, alpha};
  assign prod_g = {8'd0, c_g} * {8'd0, alpha};
  assign prod_b = {8'd0, c_b} * {8'd0, alpha};

  always_comb begin
    case (cfg.source_format)
      p2a_pkg::FMT_MONO:
        word = {p2a_pkg::OPAQUE, pix.byte0, pix.byte0, pix.byte0};
      p2a_pkg::FMT_MASK, p2a_pkg::FMT_RGBM, p2a_pkg::FMT_MRGB32:
        word = {alpha, prod_r[15:8], prod_g[15:8], prod_b[15:8]};
      p2a_pkg::FMT_RGBX, p2a_pkg::FMT_RGB:
        word = {p2a_pkg::OPAQUE, pix.byte0, pix.byte1, pix.byte2};
      p2a_pkg::FMT_RGBA:
        word = {pix.byte3, pix.byte0, pix.byte1, pix.byte2};
      default:
        word = {pix.byte3, pix.byte2, pix.byte1, pix.byte0};
    endcase
  end

  assign res.argb_word      = word;
  assign res.end_of_row_out = pix.end_of_row;

endmodule
`default_nettype wire

@@ rtl/core/pixel_to_argb32_converter.sv @@
`default_nettype none
// channel   handshake                    payload
// input     start, busy                  pixel (byte0..byte3, end_of_row)
// result    result_strobe                result (argb_word, end_of_row_out)
// config    cfg_valid, cfg_ready         cfg_index, cfg_data
//
// one pixel per cycle; a pixel taken passes through the input register, the
// conversion logic and the result register before its result strobe, with the
// three 8x8 premultiply multipliers in the conversion logic between them.
// busy is always low: the result side cannot stall and nothing backs up.
// rst is synchronous and clears the valid flags and config registers;
// source_format resets to the argb32 pass-through.
module pixel_to_argb32_converter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire p2a_pkg::pixel_t                  pixel,
  output logic                                  result_strobe,
  output p2a_pkg::result_t                      result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [p2a_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [p2a_pkg::REG_DATA_W-1:0]   cfg_data
);

  p2a_pkg::cfg_t    cfg;
  p2a_pkg::pixel_t  pix;
  logic             pix_valid;
  p2a_pkg::result_t res_next;
  p2a_pkg::result_t res;
  logic             res_valid;

  assign busy = 1'b0;

  p2a_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pix <= pixel;
    end
  end

  p2a_conv u_conv (
    .pix (pix),
    .cfg (cfg),
    .res (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid) begin
      res <= res_next;
    end
  end

  assign result_strobe = res_valid;
  assign result        = res;

endmodule
`default_nettype wire

@@ sim/argb_checker.sv @@
module argb_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  p2a_pkg::pixel_t  pixel,
  input  logic             result_strobe,
  input  p2a_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [p2a_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [p2a_pkg::REG_DATA_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import p2a_pkg::*;

  cfg_t    conv_cfg;
  result_t argb_queue[$];

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] prod;
    prod = {8'd0, c} * {8'd0, a};
    return prod[15:8];
  endfunction

  function automatic result_t convert_pixel(input pixel_t px, input cfg_t cfg);
    result_t    r;
    logic [7:0] a;
    r.end_of_row_out = px.end_of_row;
    case (cfg.source_format)
      FMT_MONO: r.argb_word = {OPAQUE, px.byte0, px.byte0, px.byte0};
      FMT_MASK: begin
        a = OPAQUE - px.byte0;
        r.argb_word = {a, premul(cfg.mask_red, a), premul(cfg.mask_green, a),
                       premul(cfg.mask_blue, a)};
      end
      FMT_RGBX, FMT_RGB: r.argb_word = {OPAQUE, px.byte0, px.byte1, px.byte2};
      FMT_RGBA: r.argb_word = {px.byte3, px.byte0, px.byte1, px.byte2};
      FMT_RGBM: r.argb_word = {px.byte3, premul(px.byte0, px.byte3),
                               premul(px.byte1, px.byte3), premul(px.byte2, px.byte3)};
      FMT_MRGB32: r.argb_word = {px.byte3, premul(px.byte2, px.byte3),
                                 premul(px.byte1, px.byte3), premul(px.byte0, px.byte3)};
      default: r.argb_word = {px.byte3, px.byte2, px.byte1, px.byte0};
    endcase
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (fail_count < 10)
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, field, want, got);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    conv_cfg = '{source_format: SOURCE_FORMAT_RESET, default: '0};
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      conv_cfg <= '{source_format: SOURCE_FORMAT_RESET, default: '0};
      argb_queue.delete();
    end else begin
      if (result_strobe) begin
        if (argb_queue.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result %h", $realtime, result);
          fail_count++;
        end else begin
          want = argb_queue.pop_front();
          if (result.argb_word !== want.argb_word)
            report_field("argb_word", want.argb_word, result.argb_word);
          if (result.end_of_row_out !== want.end_of_row_out)
            report_field("end_of_row_out", {31'd0, want.end_of_row_out},
                         {31'd0, result.end_of_row_out});
        end
      end
      // prediction uses the config in force when the pixel transfer happens
      if (start && !busy)
        argb_queue.push_back(convert_pixel(pixel, conv_cfg));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: conv_cfg.source_format <= cfg_data[FMT_W-1:0];
          REG_MASK_RED:      conv_cfg.mask_red <= cfg_data;
          REG_MASK_GREEN:    conv_cfg.mask_green <= cfg_data;
          REG_MASK_BLUE:     conv_cfg.mask_blue <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= argb_queue.size();
  end

endmodule

@@ sim/pixel_to_argb32_converter_tb.sv @@
module pixel_to_argb32_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import p2a_pkg::*;

  localparam logic [FMT_W-1:0] FORMATS [8] = '{FMT_MONO, FMT_MASK, FMT_RGBX, FMT_RGB,
                                               FMT_RGBA, FMT_ARGB32, FMT_RGBM, FMT_MRGB32};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  pixel_t                pixel = '0;
  logic                  cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  result_strobe;
  result_t               result;
  logic                  cfg_ready;
  int                    fail_count;
  int                    pending;

  pixel_to_argb32_converter DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  argb_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // caller keeps start high across back-to-back transfers
  task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input logic eor);
    start <= 1'b1;
    pixel <= '{byte0: b0, byte1: b1, byte2: b2, byte3: b3, end_of_row: eor};
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait until every pending result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_corner_pixels();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h80, 1'b0);
  endtask

  initial begin
    logic [FMT_W-1:0] fmt;
    int gap;
    bit no_idle;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset format is the argb32 pass-through
    send_corner_pixels();
    drain();
    write_reg(REG_MASK_RED, 8'hff);
    write_reg(REG_MASK_GREEN, 8'h00);
    write_reg(REG_MASK_BLUE, 8'h80);
    write_reg(REG_IDX_W'(REG_MASK_BLUE + 3'd1 + 3'($urandom_range(0, 3))), pick_byte());
    foreach (FORMATS[f]) begin
      if (FORMATS[f] != FMT_ARGB32) begin
        write_reg(REG_SOURCE_FORMAT, {{(REG_DATA_W-FMT_W){1'b0}}, FORMATS[f]});
        send_corner_pixels();
        drain();
      end
    end

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      fmt = (ph < 8) ? FORMATS[ph] : FORMATS[$urandom_range(0, 7)];
      // upper data bits carry noise; only the format width counts
      write_reg(REG_SOURCE_FORMAT, {REG_DATA_W'($urandom) & ~REG_DATA_W'(7) | fmt});
      if (ph == 1) begin
        write_reg(REG_MASK_RED, 8'hff);
        write_reg(REG_MASK_GREEN, 8'hff);
        write_reg(REG_MASK_BLUE, 8'hff);
      end else begin
        write_reg(REG_MASK_RED, pick_byte());
        write_reg(REG_MASK_GREEN, pick_byte());
        write_reg(REG_MASK_BLUE, pick_byte());
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_IDX_W'(REG_MASK_BLUE + 3'd1 + 3'($urandom_range(0, 3))), pick_byte());
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 || $urandom_range(0, 199) == 0) begin
          drain();
        end else if (!no_idle) begin
          gap = pick_gap();
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 1'($urandom));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
